// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/pip_pkg.sv -----
// Package with types and constants of the point-in-polygon block.
package pip_pkg;
	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_BITS_DEF = 16;
	localparam int RAY_OFFSET = 2000;
	localparam int CNT_BITS = 7;
	localparam logic [CNT_BITS-1:0] VCOUNT_RESET = 7'd3;
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [5:0]  vertex_index;
		logic signed [COORD_BITS_DEF-1:0] coord_x;
		logic signed [COORD_BITS_DEF-1:0] coord_y;
	} pip_in_t;

	typedef struct packed {
		logic                is_answer;
		logic                inside_res;
		logic [CNT_BITS-1:0] crossing_count;
	} pip_out_t;
endpackage

// ----- rtl/point_in_polygon_ray_cast.sv -----
// Top level of the point-in-polygon crossing-number block.
// A vertex write's acknowledge word appears the next cycle. A query walks the stored polygon
// through one memory read port and one shared two-stage edge test, one edge per cycle. The
// block accepts no word while a query runs or while a result waits to be taken.
module point_in_polygon_ray_cast import pip_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CNT_BITS-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  pip_in_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output pip_out_t out_data
);
	logic [CNT_BITS-1:0] vcount_q;

	// Vertex count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vcount_q <= VCOUNT_RESET;
		else if (cfg_we) vcount_q <= cfg_wdata;
	end

	pip_seq #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_seq (
		.clk(clk), .arst_n(arst_n), .vcount(vcount_q),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_data)
	);
endmodule

// ----- rtl/pip_edge_unit.sv -----
// Shared edge test unit: two register stages deciding one edge crossing.
module pip_edge_unit import pip_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic clk,
	input  logic start,
	input  logic signed [COORD_BITS-1:0] x1,
	input  logic signed [COORD_BITS-1:0] y1,
	input  logic signed [COORD_BITS-1:0] x2,
	input  logic signed [COORD_BITS-1:0] y2,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	output logic valid_s2,
	output logic hit_s2
);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 1;
	localparam int OW = 12;
	localparam int QW = SW + OW;

	logic signed [DW-1:0] ex, ey, wx, wy;
	logic signed [DW:0] den, tn;
	logic signed [PW-1:0] p1_s1, p2_s1;
	logic signed [DW:0] den_s1, tn_s1;
	logic valid_s1;
	logic signed [SW-1:0] sn;
	logic signed [DW:0] dab, tab;
	logic signed [SW-1:0] sab;
	logic signed [QW-1:0] sden;
	logic neg;

	// Coordinate differences and the two difference terms den and tn.
	always_comb begin
		ex = DW'(x2) - DW'(x1);
		ey = DW'(y2) - DW'(y1);
		wx = DW'(px) - DW'(x1);
		wy = DW'(py) - DW'(y1);
		den = (DW+1)'(ex) - (DW+1)'(ey);
		tn = (DW+1)'(wx) - (DW+1)'(wy);
	end

	always_ff @(posedge clk) begin
		valid_s1 <= start;
		p1_s1 <= PW'(wx) * PW'(ey);
		p2_s1 <= PW'(wy) * PW'(ex);
		den_s1 <= den;
		tn_s1 <= tn;
	end

	// Sign normalization and range checks.
	always_comb begin
		sn = SW'(p1_s1) - SW'(p2_s1);
		neg = den_s1[DW];
		dab = neg ? -den_s1 : den_s1;
		tab = neg ? -tn_s1 : tn_s1;
		sab = neg ? -sn : sn;
		sden = QW'(dab) * QW'(RAY_OFFSET);
	end

	always_ff @(posedge clk) begin
		valid_s2 <= valid_s1;
		hit_s2 <= (den_s1 != '0) && !tab[DW] && (tab <= dab) && !sab[SW-1]
			&& (QW'(sab) <= sden);
	end
endmodule

// ----- rtl/pip_seq.sv -----
// Sequencer: vertex memory, edge walk and crossing counter.
module pip_seq import pip_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [CNT_BITS-1:0] vcount,
	input  logic in_valid,
	output logic in_ready,
	input  pip_in_t in_word,
	output logic out_valid,
	input  logic out_ready,
	output pip_out_t out_word
);
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int NW = AW + 1;
	localparam logic [1:0] ST_IDLE = 2'd0, ST_RUN = 2'd1, ST_DONE = 2'd2;

	logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
	logic [1:0] state_q;
	logic [NW-1:0] n_q, idx_q, rdcnt_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic signed [COORD_BITS-1:0] px_q, py_q, x1_q, y1_q, x2_q, y2_q, fx_q, fy_q;
	logic [2*COORD_BITS-1:0] rd_q;
	logic rd_v_q, first_q, start_q;
	logic vld_s2, hit_s2;
	logic [NW-1:0] n_eff;
	logic do_start;

	// Clamp the vertex count into 3 .. MAX_VERTICES.
	always_comb begin
		if (32'(vcount) < 3) n_eff = NW'(3);
		else if (32'(vcount) > MAX_VERTICES) n_eff = NW'(MAX_VERTICES);
		else n_eff = NW'(vcount);
	end

	assign in_ready = (state_q == ST_IDLE) && !out_valid;
	assign do_start = in_valid && in_ready;

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (do_start && in_word.req_type == REQ_WRITE && 32'(in_word.vertex_index) < MAX_VERTICES)
			mem[AW'(in_word.vertex_index)] <= {COORD_BITS'(in_word.coord_y),
				COORD_BITS'(in_word.coord_x)};
		rd_q <= mem[idx_q[AW-1:0]];
	end

	// Edge walk: read vertices in order, pair each with the next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			rd_v_q <= 1'b0;
			start_q <= 1'b0;
			idx_q <= '0;
			rdcnt_q <= '0;
			n_q <= '0;
			cnt_q <= '0;
			first_q <= 1'b0;
			out_word <= '0;
		end else begin
			rd_v_q <= 1'b0;
			start_q <= 1'b0;
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (do_start) begin
						if (in_word.req_type == REQ_WRITE) begin
							out_valid <= 1'b1;
							out_word <= '0;
						end else begin
							state_q <= ST_RUN;
							n_q <= n_eff;
							idx_q <= '0;
							rdcnt_q <= '0;
							cnt_q <= '0;
							first_q <= 1'b1;
						end
					end
				end
				ST_RUN: begin
					if (idx_q <= n_q) begin
						rd_v_q <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end
					if (rd_v_q) begin
						rdcnt_q <= rdcnt_q + 1'b1;
						first_q <= 1'b0;
						if (first_q) begin
							fx_q <= rd_q[COORD_BITS-1:0];
							fy_q <= rd_q[2*COORD_BITS-1:COORD_BITS];
						end
						x1_q <= x2_q;
						y1_q <= y2_q;
						if (rdcnt_q == n_q) begin
							x2_q <= fx_q;
							y2_q <= fy_q;
						end else begin
							x2_q <= rd_q[COORD_BITS-1:0];
							y2_q <= rd_q[2*COORD_BITS-1:COORD_BITS];
						end
						if (!first_q) start_q <= 1'b1;
						if (rdcnt_q == n_q) state_q <= ST_DONE;
					end
					if (vld_s2 && hit_s2) cnt_q <= cnt_q + 1'b1;
				end
				ST_DONE: begin
					if (vld_s2 && hit_s2) cnt_q <= cnt_q + 1'b1;
					if (!vld_s2 && !start_q) begin
						state_q <= ST_IDLE;
						out_valid <= 1'b1;
						out_word.is_answer <= 1'b1;
						out_word.inside_res <= cnt_q[0];
						out_word.crossing_count <= cnt_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Query point is captured at acceptance.
	always_ff @(posedge clk) begin
		if (do_start) begin
			px_q <= COORD_BITS'(in_word.coord_x);
			py_q <= COORD_BITS'(in_word.coord_y);
		end
	end

	pip_edge_unit #(.COORD_BITS(COORD_BITS)) u_edge (
		.clk(clk), .start(start_q),
		.x1(x1_q), .y1(y1_q), .x2(x2_q), .y2(y2_q), .px(px_q), .py(py_q),
		.valid_s2(vld_s2), .hit_s2(hit_s2)
	);
endmodule

// ----- rtl/pip_checker.sv -----
// Port-level checker for the point-in-polygon block, with its bind.
`include "assert_macros.svh"
module pip_checker import pip_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input pip_in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input pip_out_t out_data
);
	`CHK_IMPL(a_one_busy, clk, arst_n, out_valid, !in_ready, "input ready while result pending")
	`CHK_NEXT(a_wr_ack, clk, arst_n, in_valid && in_ready && in_data.req_type == REQ_WRITE, out_valid && !out_data.is_answer, "no write acknowledge")
	`CHK_IMPL(a_parity, clk, arst_n, out_valid, out_data.inside_res == out_data.crossing_count[0],
		"parity mismatch")
	`CHK_IMPL(a_ack_zero, clk, arst_n, out_valid && !out_data.is_answer,
		out_data.crossing_count == '0, "ack carries count")
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result word dropped or changed while waiting")
endmodule

bind point_in_polygon_ray_cast pip_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ----- test/point_in_polygon_ray_cast_tb.sv -----
// Testbench that checks the point-in-polygon block against its own crossing-number predictor.
`timescale 1ns / 100ps

module point_in_polygon_ray_cast_tb;
	import pip_pkg::*;

	localparam int NVERT = 64;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CNT_BITS-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	pip_in_t in_data;
	logic out_valid;
	logic out_ready;
	pip_out_t out_data;

	// Words waiting to be sent and answers waiting to arrive.
	pip_in_t pending_words[$];
	pip_out_t expected_answers[$];

	// Predictor state: the polygon and the vertex count register.
	logic signed [15:0] poly_x[NVERT];
	logic signed [15:0] poly_y[NVERT];
	int vcount_reg;

	int mismatches;
	int words_sent;
	int answers_seen;
	int queries_seen;
	int inside_seen;
	int cycles;
	int send_gap;
	int recv_gap;
	int hold_cnt;
	bit hold_req;
	bit idle_on;
	bit took;

	point_in_polygon_ray_cast i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// Clock.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Exact test of one edge against the segment from P to P + (2000, 2000).
	function automatic bit edge_hit(longint x1, longint y1, longint x2, longint y2,
			longint px, longint py);
		longint ex, ey, wx, wy, den, tn, sn;
		ex = x2 - x1;
		ey = y2 - y1;
		wx = px - x1;
		wy = py - y1;
		den = ex - ey;
		tn = wx - wy;
		sn = wx * ey - wy * ex;
		if (den == 0)
			return 1'b0;
		if (den < 0) begin
			den = -den;
			tn = -tn;
			sn = -sn;
		end
		if (tn < 0 || tn > den)
			return 1'b0;
		if (sn < 0 || sn > den * RAY_OFFSET)
			return 1'b0;
		return 1'b1;
	endfunction

	// Expected result word for one accepted word; writes update the polygon.
	function automatic pip_out_t predict_answer(pip_in_t w);
		pip_out_t r;
		int n, cnt, j;
		r = '0;
		if (w.req_type == REQ_WRITE) begin
			poly_x[w.vertex_index] = w.coord_x;
			poly_y[w.vertex_index] = w.coord_y;
			return r;
		end
		n = vcount_reg;
		if (n < 3)
			n = 3;
		if (n > NVERT)
			n = NVERT;
		cnt = 0;
		for (int i = 0; i < n; i++) begin
			j = (i + 1 == n) ? 0 : i + 1;
			if (edge_hit(poly_x[i], poly_y[i], poly_x[j], poly_y[j], w.coord_x, w.coord_y))
				cnt++;
		end
		r.is_answer = 1'b1;
		r.inside_res = cnt[0];
		r.crossing_count = cnt[CNT_BITS-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (!idle_on || p < 70)
			return 0;
		if (p < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic push_write(int idx, int x, int y);
		pip_in_t w;
		w.req_type = REQ_WRITE;
		w.vertex_index = idx[5:0];
		w.coord_x = x[15:0];
		w.coord_y = y[15:0];
		pending_words.push_back(w);
	endtask

	task automatic push_query(int x, int y);
		pip_in_t w;
		w.req_type = REQ_QUERY;
		w.vertex_index = $urandom_range(63);
		w.coord_x = x[15:0];
		w.coord_y = y[15:0];
		pending_words.push_back(w);
	endtask

	// Wait until every word is sent and every answer has come back.
	task automatic drain();
		while (pending_words.size() != 0 || in_valid || expected_answers.size() != 0)
			@(posedge clk);
	endtask

	// Register write while the block is idle.
	task automatic set_vcount(int v);
		drain();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[CNT_BITS-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		vcount_reg = v & 8'h7f;
	endtask

	// Sender: offers the next word at the falling edge after a random gap.
	always @(negedge clk) begin
		logic nv;
		nv = in_valid;
		if (arst_n) begin
			if (in_valid && took)
				nv = 1'b0;
			took = 1'b0;
			if (!nv) begin
				if (send_gap > 0)
					send_gap--;
				else if (pending_words.size() != 0) begin
					in_data <= pending_words.pop_front();
					nv = 1'b1;
					send_gap = pick_gap();
				end
			end
		end
		in_valid <= nv;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			recv_gap = pick_gap();
		end
	end

	// Monitor: predicts on each accepted word and checks each result word.
	always @(posedge clk) begin
		pip_out_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_answers.push_back(predict_answer(in_data));
				words_sent++;
				took = 1'b1;
			end
			if (out_valid && out_ready) begin
				answers_seen++;
				if (expected_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result word %p", out_data);
				end else begin
					want = expected_answers.pop_front();
					if (want.is_answer)
						queries_seen++;
					if (want.inside_res)
						inside_seen++;
					if (out_data.is_answer !== want.is_answer
							|| out_data.inside_res !== want.inside_res
							|| out_data.crossing_count !== want.crossing_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected %p, got %p", want, out_data);
					end
				end
			end
		end
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		int cx, cy, r, n, p;
		int counts[10];
		counts = '{3, 64, 0, 127, 1, 65, 2, 10, 33, 5};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		mismatches = 0;
		words_sent = 0;
		answers_seen = 0;
		queries_seen = 0;
		inside_seen = 0;
		cycles = 0;
		send_gap = 0;
		recv_gap = 0;
		hold_cnt = 0;
		hold_req = 1'b0;
		idle_on = 1'b1;
		took = 1'b0;
		vcount_reg = VCOUNT_RESET;
		for (int i = 0; i < NVERT; i++) begin
			poly_x[i] = '0;
			poly_y[i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill every slot first so no query ever reads an unwritten vertex.
		for (int i = 0; i < NVERT; i++)
			push_write(i, $urandom_range(65535), $urandom_range(65535));

		// Directed: a simple triangle, extreme points, vertex hits, degenerate edges.
		push_write(0, 0, 0);
		push_write(1, 1000, 0);
		push_write(2, 0, 1000);
		push_query(100, 100);
		push_query(-500, -500);
		push_query(-2000, -2000);
		push_query(-1000, -2000);
		push_query(-32768, -32768);
		push_query(32767, 32767);
		push_query(-32768, 32767);
		push_query(5000, 5000);
		push_write(63, -32768, 32767);
		push_write(62, 32767, -32768);
		push_write(2, 1000, 1000);
		push_query(200, 100);
		push_write(1, 0, 0);
		push_query(-100, -100);
		push_write(1, 1000, 0);
		push_write(2, 0, 1000);
		push_query(-1500, 0);
		drain();

		// Random phases, each with its own vertex count and polygon.
		for (int ph = 0; ph < 12; ph++) begin
			idle_on = (ph % 3 != 1);
			if (ph < 10)
				set_vcount(counts[ph]);
			else
				set_vcount($urandom_range(127));
			n = (vcount_reg < 3) ? 3 : (vcount_reg > NVERT ? NVERT : vcount_reg);
			cx = $urandom_range(40000) - 20000;
			cy = $urandom_range(40000) - 20000;
			r = (ph % 2) ? $urandom_range(5000, 1) : $urandom_range(300, 1);
			for (int i = 0; i < n; i++)
				push_write(i, cx + $urandom_range(2 * r) - r, cy + $urandom_range(2 * r) - r);
			if (ph == 4) begin
				// Long receiver hold-off while the sender keeps offering words.
				hold_req = 1'b1;
				idle_on = 1'b0;
			end
			for (int k = 0; k < 40; k++) begin
				p = $urandom_range(99);
				if (p < 80)
					push_query(cx + $urandom_range(2 * r) - r - $urandom_range(2000),
						cy + $urandom_range(2 * r) - r - $urandom_range(2000));
				else if (p < 90)
					push_query($urandom_range(65535), $urandom_range(65535));
				else
					push_write($urandom_range(63), $urandom_range(65535), $urandom_range(65535));
			end
		end

		drain();
		repeat (80) @(posedge clk);
		$display("Covered %0d words, %0d result words, %0d queries (%0d inside).",
			words_sent, answers_seen, queries_seen, inside_seen);
		$display("Vertex counts from below 3 to above 64 were used; %0d mismatches.", mismatches);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
